// ===== design/assert_macros.svh =====
// Shared assertion shorthands, clocked on clk and masked while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MMR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MMR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/mmr_pkg.sv =====
package mmr_pkg;

	localparam int DIM_DEFAULT        = 64;
	localparam int ELEM_WIDTH_DEFAULT = 32;
	// sizes are carried in 7-bit registers and clamped so that no size exceeds 64
	localparam int MAX_SIZE           = 64;

	localparam int TYPE_W      = 2;
	localparam int IDX_W       = 6;
	localparam int VALUE_W     = 32;
	localparam int ACC_W       = 64;
	localparam int SIZE_W      = 7;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = SIZE_W;

	typedef logic signed [ACC_W-1:0] acc_t;

	typedef enum logic [TYPE_W-1:0] {
		REQ_LOAD_A  = 2'd0,
		REQ_LOAD_B  = 2'd1,
		REQ_COMPUTE = 2'd2
	} req_type_t;

	localparam logic [CFG_INDEX_W-1:0] CFG_INNER_SIZE  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROWS_IN_USE = 1'b1;

	localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// Signed add that clamps at the Q32.32 limits.
	function automatic acc_t sat_add(acc_t a, acc_t b);
		acc_t s;
		s = a + b;
		if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
			return a[ACC_W-1] ? ACC_MIN : ACC_MAX;
		end
		return s;
	endfunction

endpackage

// ===== design/mmr_req_if.sv =====
interface mmr_req_if;
	import mmr_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [TYPE_W-1:0]         req_type;
	logic [IDX_W-1:0]          row;
	logic [IDX_W-1:0]          col;
	logic signed [VALUE_W-1:0] value;

	modport source(output valid, req_type, row, col, value, input ready);
	modport sink(input valid, req_type, row, col, value, output ready);
endinterface

// ===== design/mmr_res_if.sv =====
interface mmr_res_if;
	import mmr_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [IDX_W-1:0]        out_row;
	logic [IDX_W-1:0]        out_col;
	logic signed [ACC_W-1:0] out_value;
	logic                    last;
	logic                    error;

	modport source(output valid, out_row, out_col, out_value, last, error, input ready);
	modport sink(input valid, out_row, out_col, out_value, last, error, output ready);
endinterface

// ===== design/matrix_multiply_rows.sv =====
// Channel  | Dir | Payload                                   | Transaction
// req      | in  | req_type, row, col, value (Q16.16)        | load A/B element or compute a row
// res      | out | out_row, out_col, out_value (Q32.32),     | one element of the row of C
//          |     | last, error                               |
// cfg      | in  | cfg_we, cfg_index, cfg_wdata              | write inner_size / rows_in_use
//
// A load is written at the edge that accepts it. A compute of a row walks the columns in turn:
// per column the single multiply-accumulate unit walks inner_size products, fed by
// one read port on each element memory, then the pipeline drains into the accumulator.
// A row outside rows_in_use gives one error transaction through the ST_ERR state.
// Reset (arst_n low, asynchronous) clears control state and sets both sizes to the largest
// supported value; the element memories are not cleared.
// While the result register is full and not taken, the column in flight holds in the
// accumulator; req is only ready between transactions of compute.
`include "assert_macros.svh"

module matrix_multiply_rows #(
	parameter int DIM        = mmr_pkg::DIM_DEFAULT,
	parameter int ELEM_WIDTH = mmr_pkg::ELEM_WIDTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	mmr_req_if.sink                           req,
	mmr_res_if.source                         res,
	input  logic                              cfg_we,
	input  logic [mmr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [mmr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import mmr_pkg::*;

	localparam int SizeLimit = (DIM < MAX_SIZE) ? DIM : MAX_SIZE;
	localparam int Depth     = DIM * DIM;
	localparam int AW        = $clog2(Depth);
	localparam logic [SIZE_W-1:0] SizeLimitQ = SIZE_W'(SizeLimit);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ISSUE = 5'b00010,
		ST_WAIT  = 5'b00100,
		ST_PUSH  = 5'b01000,
		ST_ERR   = 5'b10000
	} state_t;

	state_t state_q;

	logic [SIZE_W-1:0] inner_q;
	logic [SIZE_W-1:0] rows_q;
	logic [SIZE_W-1:0] cfg_size;

	// element memories, indexed row * DIM + col
	logic [ELEM_WIDTH-1:0] a_mem [Depth];
	logic [ELEM_WIDTH-1:0] b_mem [Depth];

	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] j_q;

	logic                           valid_s1, last_s1;
	logic                           valid_s2, last_s2;
	logic signed [ELEM_WIDTH-1:0]   rd_a_s1, rd_b_s1;
	logic signed [2*ELEM_WIDTH-1:0] prod_s2;
	acc_t                           acc_q;

	logic             res_valid_q;
	logic [IDX_W-1:0] res_row_q;
	logic [IDX_W-1:0] res_col_q;
	acc_t             res_value_q;
	logic             res_last_q;
	logic             res_error_q;

	logic          req_fire;
	logic          load_a, load_b, start_row, start_err;
	logic          issue, k_last, j_last;
	logic          out_free, push_fire, err_fire;
	logic [AW-1:0] wr_addr, rd_a_addr, rd_b_addr;

	// Size registers: zero reads as one, anything above the limit as the limit.
	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_size = SIZE_W'(1);
		end else if (cfg_wdata > SizeLimitQ) begin
			cfg_size = SizeLimitQ;
		end else begin
			cfg_size = cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= SizeLimitQ;
			rows_q  <= SizeLimitQ;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INNER_SIZE:  inner_q <= cfg_size;
				CFG_ROWS_IN_USE: rows_q  <= cfg_size;
				default: ;
			endcase
		end
	end

	// Accept only between computes; a load never overlaps a read of the memories.
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;

	assign load_a = req_fire && req.req_type == REQ_LOAD_A
		&& SIZE_W'(req.row) < rows_q && SIZE_W'(req.col) < inner_q;
	assign load_b = req_fire && req.req_type == REQ_LOAD_B
		&& SIZE_W'(req.row) < inner_q && SIZE_W'(req.col) < inner_q;
	assign start_row = req_fire && req.req_type == REQ_COMPUTE && SIZE_W'(req.row) < rows_q;
	assign start_err = req_fire && req.req_type == REQ_COMPUTE && SIZE_W'(req.row) >= rows_q;

	assign issue  = (state_q == ST_ISSUE);
	assign k_last = (SIZE_W'(k_q) + SIZE_W'(1)) == inner_q;
	assign j_last = (SIZE_W'(j_q) + SIZE_W'(1)) == inner_q;

	assign out_free  = !res_valid_q || res.ready;
	assign push_fire = (state_q == ST_PUSH) && out_free;
	assign err_fire  = (state_q == ST_ERR) && out_free;

	assign wr_addr   = AW'(AW'(req.row) * AW'(DIM) + AW'(req.col));
	assign rd_a_addr = AW'(AW'(row_q) * AW'(DIM) + AW'(k_q));
	assign rd_b_addr = AW'(AW'(k_q) * AW'(DIM) + AW'(j_q));

	// Write loads, read A[row][k] and B[k][j] while issuing.
	always_ff @(posedge clk) begin
		if (load_a) begin
			a_mem[wr_addr] <= req.value[ELEM_WIDTH-1:0];
		end
		if (load_b) begin
			b_mem[wr_addr] <= req.value[ELEM_WIDTH-1:0];
		end
		if (issue) begin
			rd_a_s1 <= a_mem[rd_a_addr];
			rd_b_s1 <= b_mem[rd_b_addr];
		end
	end

	// Sequencer: walk k per column j, hand the sum to the result register; ST_ERR takes bad rows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			k_q         <= '0;
			j_q         <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;

			if (push_fire || err_fire) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (start_row) begin
						row_q   <= req.row;
						k_q     <= '0;
						j_q     <= '0;
						state_q <= ST_ISSUE;
					end else if (start_err) begin
						row_q   <= req.row;
						state_q <= ST_ERR;
					end
				end
				ST_ISSUE: begin
					k_q <= k_q + IDX_W'(1);
					if (k_last) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					// advance once the final product of the column is summed
					if (valid_s2 && last_s2) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						if (j_last) begin
							state_q <= ST_IDLE;
						end else begin
							j_q     <= j_q + IDX_W'(1);
							k_q     <= '0;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ERR: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Multiply, then accumulate with saturation after every addition, and load the result register.
	always_ff @(posedge clk) begin
		last_s1 <= k_last;
		last_s2 <= last_s1;
		prod_s2 <= (2*ELEM_WIDTH)'(rd_a_s1) * (2*ELEM_WIDTH)'(rd_b_s1);

		if (start_row || push_fire) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= sat_add(acc_q, ACC_W'(prod_s2));
		end

		if (push_fire) begin
			res_row_q   <= row_q;
			res_col_q   <= j_q;
			res_value_q <= acc_q;
			res_last_q  <= j_last;
			res_error_q <= 1'b0;
		end else if (err_fire) begin
			res_row_q   <= row_q;
			res_col_q   <= '0;
			res_value_q <= '0;
			res_last_q  <= 1'b1;
			res_error_q <= 1'b1;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.out_row   = res_row_q;
	assign res.out_col   = res_col_q;
	assign res.out_value = res_value_q;
	assign res.last      = res_last_q;
	assign res.error     = res_error_q;

	`MMR_ASSERT_NOW(a_pipe_in_compute, valid_s2, state_q == ST_ISSUE || state_q == ST_WAIT, "MAC pipeline active outside a column")
	`MMR_ASSERT_NOW(a_push_drained, state_q == ST_PUSH, !valid_s1 && !valid_s2, "column handed off before the pipeline drained")
	`MMR_ASSERT_NOW(a_k_in_range, issue, SIZE_W'(k_q) < inner_q, "product index past inner_size")
	`MMR_ASSERT_NEXT(a_err_shape, err_fire, res.valid && res.error && res.last && res.out_col == '0, "malformed error result")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import mmr_pkg::*;

	// The element stores are DIM x DIM, addressed row * GRID + col.
	localparam int GRID = DIM_DEFAULT;

	// Request type 3 has no meaning; the block must drop it without a result.
	localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

	localparam logic [VALUE_W-1:0] ELEM_MIN = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] ELEM_MAX = 32'h7FFF_FFFF;
	localparam logic [VALUE_W-1:0] ELEM_ONE = 32'h0001_0000;

	// Settle time after the last result, so that the block is surely idle.
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 10_000_000;

	// Long receiver hold-off, placed once after this many results.
	localparam int HOLD_AFTER  = 40;
	localparam int HOLD_CYCLES = 600;

	// One row of the opening stimulus. Where known is set, the outcome is
	// typed in: a load or unused request gives nothing, a compute gives the
	// single error transaction of a row outside rows_in_use.
	typedef struct packed {
		logic [TYPE_W-1:0]  kind;
		logic [IDX_W-1:0]   row;
		logic [IDX_W-1:0]   col;
		logic [VALUE_W-1:0] value;
		logic               known;
	} stim_row_t;

	// Opening part runs with inner_size 3 and rows_in_use 2.
	// Row 0 of A is all most-negative, so C[0][0] saturates high, C[0][1]
	// saturates low and C[0][2] saturates high and then comes back down.
	localparam int OPENING_ROWS = 24;
	localparam stim_row_t OPENING [0:OPENING_ROWS-1] = '{
		'{REQ_LOAD_B,  6'd0,  6'd0,  ELEM_MIN,      1'b0},
		'{REQ_LOAD_B,  6'd1,  6'd0,  ELEM_MIN,      1'b0},
		'{REQ_LOAD_B,  6'd2,  6'd0,  ELEM_MIN,      1'b0},
		'{REQ_LOAD_B,  6'd0,  6'd1,  ELEM_MAX,      1'b0},
		'{REQ_LOAD_B,  6'd1,  6'd1,  ELEM_MAX,      1'b0},
		'{REQ_LOAD_B,  6'd2,  6'd1,  ELEM_MAX,      1'b0},
		'{REQ_LOAD_B,  6'd0,  6'd2,  ELEM_MIN,      1'b0},
		'{REQ_LOAD_B,  6'd1,  6'd2,  ELEM_MIN,      1'b0},
		'{REQ_LOAD_B,  6'd2,  6'd2,  ELEM_MAX,      1'b0},
		'{REQ_LOAD_A,  6'd0,  6'd0,  ELEM_MIN,      1'b0},
		'{REQ_LOAD_A,  6'd0,  6'd1,  ELEM_MIN,      1'b0},
		'{REQ_LOAD_A,  6'd0,  6'd2,  ELEM_MIN,      1'b0},
		'{REQ_LOAD_A,  6'd1,  6'd0,  ELEM_MAX,      1'b0},
		'{REQ_LOAD_A,  6'd1,  6'd1,  32'h0,         1'b0},
		'{REQ_LOAD_A,  6'd1,  6'd2,  ELEM_ONE,      1'b0},
		// unused type aimed at a live cell: must not disturb A or B
		'{REQ_UNUSED,  6'd0,  6'd0,  32'h1234_5678, 1'b1},
		// loads outside the sizes in use: dropped
		'{REQ_LOAD_A,  6'd2,  6'd0,  32'h5555_5555, 1'b1},
		'{REQ_LOAD_A,  6'd0,  6'd3,  32'hAAAA_AAAA, 1'b1},
		'{REQ_LOAD_B,  6'd3,  6'd0,  32'hFFFF_FFFF, 1'b1},
		'{REQ_LOAD_B,  6'd63, 6'd63, 32'h0F0F_0F0F, 1'b1},
		'{REQ_COMPUTE, 6'd0,  6'd0,  32'h0,         1'b0},
		'{REQ_COMPUTE, 6'd1,  6'd63, 32'hFFFF_FFFF, 1'b0},
		// rows outside rows_in_use: one error transaction each
		'{REQ_COMPUTE, 6'd2,  6'd0,  32'h0,         1'b1},
		'{REQ_COMPUTE, 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b1}
	};

	// Random phases: raw register values (0 and 127 hit the clamps) and
	// the number of random requests.
	localparam int PHASES = 9;
	localparam logic [SIZE_W-1:0] PHASE_INNER [0:PHASES-1] =
		'{7'd1, 7'd0, 7'd5, 7'd6, 7'd2, 7'd3, 7'd2, 7'd4, 7'd7};
	localparam logic [SIZE_W-1:0] PHASE_ROWS [0:PHASES-1] =
		'{7'd127, 7'd0, 7'd4, 7'd4, 7'd5, 7'd2, 7'd3, 7'd1, 7'd6};
	localparam int PHASE_ITEMS [0:PHASES-1] =
		'{20, 15, 25, 25, 20, 15, 12, 15, 15};

	typedef struct {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		acc_t             value;
		logic             last;
		logic             error;
	} c_elem_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	mmr_req_if req_ch();
	mmr_res_if res_ch();

	matrix_multiply_rows uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Mirror of the block: element stores, which cells hold data, sizes.
	logic signed [VALUE_W-1:0] a_elems [GRID*GRID];
	logic signed [VALUE_W-1:0] b_elems [GRID*GRID];
	bit                        a_loaded [GRID*GRID];
	bit                        b_loaded [GRID*GRID];
	int unsigned               cur_inner;
	int unsigned               cur_rows;

	// Elements of C still owed by the block, oldest first.
	c_elem_t c_row_elems [$];

	int unsigned failures;
	int unsigned elems_taken;
	int unsigned cycle_count;
	bit          send_calm;
	bit          take_calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a run that hangs is a failed run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("matrix_multiply_rows verification failed");
			$finish;
		end
	end

	function automatic int unsigned clamp_size(logic [SIZE_W-1:0] raw);
		if (raw == 0)
			return 1;
		if (raw > MAX_SIZE)
			return MAX_SIZE;
		return 32'(raw);
	endfunction

	// Element values lean on the extremes so that sums saturate often.
	function automatic logic [VALUE_W-1:0] draw_value();
		case ($urandom_range(0, 7))
			0: return ELEM_MIN;
			1: return ELEM_MAX;
			2: return VALUE_W'($urandom_range(0, 131071)) - 32'd65536;
			default: return $urandom;
		endcase
	endfunction

	// Apply one accepted request to the mirror. Loads update the stores; unless its outcome is typed
	// in, a compute queues the row of C, each sum clamped after every add, or its error transaction.
	function automatic void mirror_request(logic [TYPE_W-1:0] kind, logic [IDX_W-1:0] row,
			logic [IDX_W-1:0] col, logic [VALUE_W-1:0] value, bit queue_results);
		c_elem_t                 elem;
		acc_t                    sum;
		acc_t                    prod;
		logic signed [ACC_W:0]   wide;
		int unsigned             slot;
		slot = int'(row) * GRID + int'(col);
		case (kind)
			REQ_LOAD_A: begin
				if (row < cur_rows && col < cur_inner) begin
					a_elems[slot]  = value;
					a_loaded[slot] = 1'b1;
				end
			end
			REQ_LOAD_B: begin
				if (row < cur_inner && col < cur_inner) begin
					b_elems[slot]  = value;
					b_loaded[slot] = 1'b1;
				end
			end
			REQ_COMPUTE: begin
				if (!queue_results) begin
					// outcome is typed in by the caller
				end else if (row >= cur_rows) begin
					elem.row   = row;
					elem.col   = '0;
					elem.value = '0;
					elem.last  = 1'b1;
					elem.error = 1'b1;
					c_row_elems.push_back(elem);
				end else begin
					for (int unsigned j = 0; j < cur_inner; j++) begin
						sum = '0;
						for (int unsigned k = 0; k < cur_inner; k++) begin
							prod = acc_t'(a_elems[int'(row) * GRID + k]) *
								acc_t'(b_elems[k * GRID + j]);
							wide = {sum[ACC_W-1], sum} + {prod[ACC_W-1], prod};
							if (wide[ACC_W] != wide[ACC_W-1])
								sum = wide[ACC_W] ? ACC_MIN : ACC_MAX;
							else
								sum = wide[ACC_W-1:0];
						end
						elem.row   = row;
						elem.col   = IDX_W'(j);
						elem.value = sum;
						elem.last  = (j + 1 == cur_inner);
						elem.error = 1'b0;
						c_row_elems.push_back(elem);
					end
				end
			end
			default: begin
				// unused request type: dropped
			end
		endcase
	endfunction

	// Offer one request after a random gap and hold it until the block
	// takes the transaction. Entered and left at a falling edge; valid is
	// only lowered when a gap follows, so it never toggles within a step.
	task automatic send_req(logic [TYPE_W-1:0] kind, logic [IDX_W-1:0] row,
			logic [IDX_W-1:0] col, logic [VALUE_W-1:0] value, bit known);
		int unsigned gap;
		c_elem_t     elem;
		if ($urandom_range(0, 19) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.row      <= row;
		req_ch.col      <= col;
		req_ch.value    <= value;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		mirror_request(kind, row, col, value, !known);
		// typed-in compute rows are all out of range: one error transaction
		if (known && kind == REQ_COMPUTE) begin
			elem.row   = row;
			elem.col   = '0;
			elem.value = '0;
			elem.last  = 1'b1;
			elem.error = 1'b1;
			c_row_elems.push_back(elem);
		end
		@(negedge clk);
	endtask

	// Drop valid, wait out every owed result, then let the block settle.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (c_row_elems.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write both size registers, inner_size and then rows_in_use, on consecutive edges; write enable
	// stays high across them.
	task automatic set_sizes(logic [SIZE_W-1:0] inner_raw, logic [SIZE_W-1:0] rows_raw);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_INNER_SIZE;
		cfg_wdata <= inner_raw;
		@(negedge clk);
		cfg_index <= CFG_ROWS_IN_USE;
		cfg_wdata <= rows_raw;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_inner = clamp_size(inner_raw);
		cur_rows  = clamp_size(rows_raw);
	endtask

	// Request side.
	initial begin
		logic [TYPE_W-1:0]  kind;
		logic [IDX_W-1:0]   row;
		logic [IDX_W-1:0]   col;
		logic [VALUE_W-1:0] value;
		int unsigned        pick;

		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_wdata       = '0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = '0;
		req_ch.row      = '0;
		req_ch.col      = '0;
		req_ch.value    = '0;
		send_calm       = 1'b0;
		cur_inner       = MAX_SIZE;
		cur_rows        = MAX_SIZE;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_sizes(7'd3, 7'd2);
		for (int i = 0; i < OPENING_ROWS; i++)
			send_req(OPENING[i].kind, OPENING[i].row, OPENING[i].col,
				OPENING[i].value, OPENING[i].known);

		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			set_sizes(PHASE_INNER[p], PHASE_ROWS[p]);

			// Fill every cell a compute may read that holds no data yet, so
			// no compute ever touches an unwritten element.
			for (int unsigned k = 0; k < cur_inner; k++)
				for (int unsigned j = 0; j < cur_inner; j++)
					if (!b_loaded[k * GRID + j])
						send_req(REQ_LOAD_B, IDX_W'(k), IDX_W'(j), draw_value(), 1'b0);
			for (int unsigned r = 0; r < cur_rows; r++)
				for (int unsigned k = 0; k < cur_inner; k++)
					if (!a_loaded[r * GRID + k])
						send_req(REQ_LOAD_A, IDX_W'(r), IDX_W'(k), draw_value(), 1'b0);

			// Random mix: mostly in-range loads and row computes, the rest
			// error rows (where rows_in_use leaves any), loads anywhere and unused types.
			for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
				pick  = $urandom_range(0, 99);
				kind  = REQ_COMPUTE;
				row   = IDX_W'($urandom_range(0, 63));
				col   = IDX_W'($urandom_range(0, 63));
				value = draw_value();
				if (pick < 45) begin
					kind = $urandom_range(0, 1) ? REQ_LOAD_B : REQ_LOAD_A;
					row  = IDX_W'($urandom_range(0,
						(kind == REQ_LOAD_A ? cur_rows : cur_inner) - 1));
					col  = IDX_W'($urandom_range(0, cur_inner - 1));
				end else if (pick < 72) begin
					row = IDX_W'($urandom_range(0, cur_rows - 1));
				end else if (pick < 82) begin
					if (cur_rows < MAX_SIZE)
						row = IDX_W'($urandom_range(63, cur_rows));
					else
						row = IDX_W'($urandom_range(0, cur_rows - 1));
				end else if (pick < 94) begin
					kind = $urandom_range(0, 1) ? REQ_LOAD_B : REQ_LOAD_A;
				end else begin
					kind = REQ_UNUSED;
				end
				send_req(kind, row, col, value, 1'b0);
			end
		end

		drain_results();
		if (failures == 0)
			$display("matrix_multiply_rows verification clean");
		else
			$display("matrix_multiply_rows verification failed");
		$finish;
	end

	// Result side: stall at random, once for a long stretch so that the
	// block backs up into its request channel, and check every transaction.
	initial begin
		int unsigned hold;
		c_elem_t     want;

		res_ch.ready = 1'b0;
		elems_taken  = 0;
		take_calm    = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 19) == 0)
				take_calm = !take_calm;
			if (elems_taken == HOLD_AFTER)
				hold = HOLD_CYCLES;
			else
				hold = take_calm ? 0 : $urandom_range(0, 16);
			if (hold != 0) begin
				res_ch.ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (res_ch.valid !== 1'b1);
			elems_taken++;
			if (c_row_elems.size() == 0) begin
				failures++;
				$display("%0t: result with nothing owed: row %0d col %0d value %0d last %b error %b",
					$time, res_ch.out_row, res_ch.out_col, res_ch.out_value,
					res_ch.last, res_ch.error);
			end else begin
				want = c_row_elems.pop_front();
				if (res_ch.out_row !== want.row || res_ch.out_col !== want.col ||
						res_ch.out_value !== want.value || res_ch.last !== want.last ||
						res_ch.error !== want.error) begin
					failures++;
					$display("%0t: C mismatch: expected row %0d col %0d value %0d last %b error %b",
						$time, want.row, want.col, want.value, want.last, want.error);
					$display("%0t:             got row %0d col %0d value %0d last %b error %b",
						$time, res_ch.out_row, res_ch.out_col, res_ch.out_value,
						res_ch.last, res_ch.error);
				end
			end
			@(negedge clk);
		end
	end

endmodule
